// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define PMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define PMS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// File: hw/rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Types and codes shared by the priority message scheduler.
// ----------------------------------------------------------------------------
package pms_pkg;

  // action codes
  localparam logic [1:0] ACT_POST     = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TASK = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // configuration register indexes
  localparam logic CFG_TASK_PRIORITIES = 1'b0;
  localparam logic CFG_TASK_COUNT      = 1'b1;

  // at most this many freed handles per remove
  localparam int MAX_FREED = 32;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] task_id;
    logic [7:0] signal;
    logic [4:0] message_handle;
    logic [3:0] priority_floor;
  } msg_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       handle_valid;
    logic [4:0] out_handle;
    logic [3:0] out_task;
    logic [7:0] out_signal;
    logic [3:0] out_priority;
    logic [5:0] removed_count;
    logic [7:0] ready_mask;
    logic       last;
  } msg_out_t;

  typedef enum logic [2:0] {
    CMD_POST,
    CMD_DISPATCH,
    CMD_REMOVE,
    CMD_BAD,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] task_id;
    logic [7:0] signal;
    logic [4:0] slot;
    logic [3:0] pri;
    logic [3:0] floor_pri;
  } pms_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_POST,
    BK_POST_LINK,
    BK_REPLY,
    BK_DISP,
    BK_DISP_OUT,
    BK_RM_START,
    BK_RM_ISSUE,
    BK_RM_EVAL,
    BK_RM_FRD,
    BK_RM_EMIT,
    BK_RM_CLOSE
  } back_state_t;

endpackage

// File: hw/rtl/pms_front.sv
// ----------------------------------------------------------------------------
// pms_front
// Holds configuration, accepts input beats and classifies them into commands.
// ----------------------------------------------------------------------------
module pms_front #(
  parameter int NUM_PRIORITIES = 8,
  parameter int MSG_SLOTS      = 32,
  parameter int MAX_TASKS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pms_pkg::msg_in_t  in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output pms_pkg::pms_cmd_t cmd,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data
);

  logic [63:0] task_priorities;
  logic [4:0]  task_count;
  logic [4:0]  mod_tbl [32];
  logic [3:0]  nib;
  logic        tid_ok;
  logic        pri_ok;

  // handle modulo slot count, folded into a constant table
  for (genvar i = 0; i < 32; i++) begin : g_mod
    assign mod_tbl[i] = 5'(i % MSG_SLOTS);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_priorities <= 64'h1111111111111111;
      task_count      <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pms_pkg::CFG_TASK_PRIORITIES) begin
        task_priorities <= cfg_data;
      end else begin
        task_count <= cfg_data[4:0];
      end
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    nib    = task_priorities[{in_data.task_id, 2'b00} +: 4];
    tid_ok = ({1'b0, in_data.task_id} < task_count) &&
             ({1'b0, in_data.task_id} < 5'(MAX_TASKS));
    pri_ok = (nib != 4'd0) && ({1'b0, nib} <= 5'(NUM_PRIORITIES));

    cmd.task_id   = in_data.task_id;
    cmd.signal    = in_data.signal;
    cmd.slot      = mod_tbl[in_data.message_handle];
    cmd.pri       = nib;
    cmd.floor_pri = in_data.priority_floor;
    case (in_data.action)
      pms_pkg::ACT_POST: begin
        cmd.kind = (tid_ok && pri_ok) ? pms_pkg::CMD_POST : pms_pkg::CMD_BAD;
      end
      pms_pkg::ACT_DISPATCH: begin
        cmd.kind = pms_pkg::CMD_DISPATCH;
      end
      pms_pkg::ACT_REMOVE: begin
        cmd.kind = (tid_ok && pri_ok) ? pms_pkg::CMD_REMOVE : pms_pkg::CMD_BAD;
      end
      default: begin
        cmd.kind = pms_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

// File: hw/rtl/pms_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pms_cmd_fifo
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pms_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pms_pkg::pms_cmd_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output pms_pkg::pms_cmd_t rd_data
);

  pms_pkg::pms_cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/pms_back.sv
// ----------------------------------------------------------------------------
// pms_back
// Carries out queued commands on the priority queues and link memories.
// ----------------------------------------------------------------------------
module pms_back #(
  parameter int NUM_PRIORITIES = 8,
  parameter int MSG_SLOTS      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pms_pkg::pms_cmd_t cmd_in,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output pms_pkg::msg_out_t out_data
);

  localparam int SW  = $clog2(MSG_SLOTS);
  localparam int QW  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int STW = $clog2(MSG_SLOTS + 1);

  pms_pkg::back_state_t state, state_next;
  pms_pkg::pms_cmd_t    cmd;

  logic [NUM_PRIORITIES-1:0] ready;
  logic [SW-1:0] head [NUM_PRIORITIES];
  logic [SW-1:0] tail [NUM_PRIORITIES];

  // slot memories: link (has_next, next) and message info (task, signal)
  logic [SW:0]   link_mem [MSG_SLOTS];
  logic [11:0]   info_mem [MSG_SLOTS];
  logic [4:0]    freed_mem [pms_pkg::MAX_FREED];
  logic [SW:0]   link_rd;
  logic [11:0]   info_rd;
  logic [4:0]    freed_rd;

  logic [SW-1:0] cur, prev;
  logic          prevv, walk_v;
  logic [STW-1:0] steps;
  logic [5:0]    nfree;
  logic [4:0]    emit_idx;
  logic [1:0]    reply_status;
  logic [QW-1:0] qsel;

  logic          obuf_free;
  logic          load_out;
  pms_pkg::msg_out_t res;

  logic [SW-1:0] slot;
  logic [QW-1:0] q_cmd;
  logic [3:0]    top;
  logic [QW-1:0] top_q;
  logic          disp_ok;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] nxt;
  logic          nv;
  logic          match;
  logic          walk_go;
  logic          link_we;
  logic [SW-1:0] link_wa;
  logic [SW:0]   link_wd;
  logic [NUM_PRIORITIES-1:0] ready_after;

  assign obuf_free = !out_valid || !out_stall;
  assign slot      = SW'(cmd.slot);
  assign q_cmd     = QW'(cmd.pri - 4'd1);
  assign nxt       = link_rd[SW-1:0];
  assign nv        = link_rd[SW];
  assign match     = (info_rd[11:8] == cmd.task_id) && (info_rd[7:0] == cmd.signal);
  assign walk_go   = walk_v && (steps < STW'(MSG_SLOTS)) &&
                     (nfree < 6'(pms_pkg::MAX_FREED));

  // highest ready priority
  always_comb begin
    top = 4'd0;
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      if (ready[i]) begin
        top = 4'(i + 1);
      end
    end
    top_q   = QW'(top - 4'd1);
    disp_ok = (top != 4'd0) && (top > cmd.floor_pri);
  end

  // keep the served head on the read port while its result waits
  assign rd_addr = (state == pms_pkg::BK_DISP)     ? head[top_q] :
                   (state == pms_pkg::BK_DISP_OUT) ? head[qsel]  : cur;

  always_comb begin
    link_we = 1'b0;
    link_wa = slot;
    link_wd = '0;
    case (state)
      pms_pkg::BK_POST: begin
        link_we = 1'b1;
      end
      pms_pkg::BK_POST_LINK: begin
        link_we = 1'b1;
        link_wa = tail[q_cmd];
        link_wd = {1'b1, slot};
      end
      pms_pkg::BK_RM_EVAL: begin
        link_we = match && prevv;
        link_wa = prev;
        link_wd = {nv, nxt};
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (state == pms_pkg::BK_POST) begin
      info_mem[slot] <= {cmd.task_id, cmd.signal};
    end
    if (state == pms_pkg::BK_RM_EVAL && match) begin
      freed_mem[nfree[4:0]] <= 5'(cur);
    end
    link_rd  <= link_mem[rd_addr];
    info_rd  <= info_mem[rd_addr];
    freed_rd <= freed_mem[emit_idx];
  end

  // next state and result assembly
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_out    = 1'b0;
    ready_after = ready;
    res         = '0;
    res.last    = 1'b1;
    case (state)
      pms_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd_in.kind)
            pms_pkg::CMD_POST:     state_next = pms_pkg::BK_POST;
            pms_pkg::CMD_DISPATCH: state_next = pms_pkg::BK_DISP;
            pms_pkg::CMD_REMOVE:   state_next = pms_pkg::BK_RM_START;
            default:               state_next = pms_pkg::BK_REPLY;
          endcase
        end
      end
      pms_pkg::BK_POST: begin
        state_next = ready[q_cmd] ? pms_pkg::BK_POST_LINK : pms_pkg::BK_REPLY;
      end
      pms_pkg::BK_POST_LINK: begin
        state_next = pms_pkg::BK_REPLY;
      end
      pms_pkg::BK_REPLY: begin
        res.status = reply_status;
        if (obuf_free) begin
          load_out   = 1'b1;
          state_next = pms_pkg::BK_IDLE;
        end
      end
      pms_pkg::BK_DISP: begin
        state_next = disp_ok ? pms_pkg::BK_DISP_OUT : pms_pkg::BK_REPLY;
      end
      pms_pkg::BK_DISP_OUT: begin
        if (!nv) begin
          ready_after[qsel] = 1'b0;
        end
        res.handle_valid = 1'b1;
        res.out_handle   = 5'(head[qsel]);
        res.out_task     = info_rd[11:8];
        res.out_signal   = info_rd[7:0];
        res.out_priority = 4'(qsel) + 4'd1;
        if (obuf_free) begin
          load_out   = 1'b1;
          state_next = pms_pkg::BK_IDLE;
        end
      end
      pms_pkg::BK_RM_START: begin
        state_next = pms_pkg::BK_RM_ISSUE;
      end
      pms_pkg::BK_RM_ISSUE: begin
        if (walk_go) begin
          state_next = pms_pkg::BK_RM_EVAL;
        end else if (nfree == 6'd0) begin
          state_next = pms_pkg::BK_RM_CLOSE;
        end else begin
          state_next = pms_pkg::BK_RM_FRD;
        end
      end
      pms_pkg::BK_RM_EVAL: begin
        state_next = pms_pkg::BK_RM_ISSUE;
      end
      pms_pkg::BK_RM_FRD: begin
        state_next = pms_pkg::BK_RM_EMIT;
      end
      pms_pkg::BK_RM_EMIT: begin
        res.handle_valid = 1'b1;
        res.out_handle   = freed_rd;
        res.out_task     = cmd.task_id;
        res.out_signal   = cmd.signal;
        res.out_priority = cmd.pri;
        res.last         = 1'b0;
        if (obuf_free) begin
          load_out   = 1'b1;
          state_next = (6'(emit_idx) + 6'd1 == nfree) ? pms_pkg::BK_RM_CLOSE
                                                      : pms_pkg::BK_RM_FRD;
        end
      end
      pms_pkg::BK_RM_CLOSE: begin
        res.out_priority  = cmd.pri;
        res.removed_count = nfree;
        if (obuf_free) begin
          load_out   = 1'b1;
          state_next = pms_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = pms_pkg::BK_IDLE;
      end
    endcase
    res.ready_mask = 8'(ready_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pms_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ready bitmap and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ready     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == pms_pkg::BK_POST && !ready[q_cmd]) begin
        ready[q_cmd] <= 1'b1;
      end
      if (state == pms_pkg::BK_DISP_OUT && load_out) begin
        ready <= ready_after;
      end
      if (state == pms_pkg::BK_RM_EVAL && match && !nv && !prevv) begin
        ready[q_cmd] <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
    case (state)
      pms_pkg::BK_IDLE: begin
        cmd          <= cmd_in;
        reply_status <= (cmd_in.kind == pms_pkg::CMD_BAD) ? pms_pkg::ST_BAD_TASK
                                                          : pms_pkg::ST_OK;
      end
      pms_pkg::BK_POST: begin
        if (!ready[q_cmd]) begin
          head[q_cmd] <= slot;
          tail[q_cmd] <= slot;
        end
      end
      pms_pkg::BK_POST_LINK: begin
        tail[q_cmd] <= slot;
      end
      pms_pkg::BK_DISP: begin
        qsel <= top_q;
        if (!disp_ok) begin
          reply_status <= pms_pkg::ST_EMPTY;
        end
      end
      pms_pkg::BK_DISP_OUT: begin
        if (load_out && nv) begin
          head[qsel] <= nxt;
        end
      end
      pms_pkg::BK_RM_START: begin
        cur    <= head[q_cmd];
        walk_v <= ready[q_cmd];
        prevv  <= 1'b0;
        steps  <= '0;
        nfree  <= 6'd0;
      end
      pms_pkg::BK_RM_ISSUE: begin
        emit_idx <= 5'd0;
      end
      pms_pkg::BK_RM_EVAL: begin
        steps  <= steps + STW'(1);
        cur    <= nxt;
        walk_v <= nv;
        if (match) begin
          nfree <= nfree + 6'd1;
          if (!prevv) begin
            head[q_cmd] <= nxt;
          end
          if (!nv && prevv) begin
            tail[q_cmd] <= prev;
          end
        end else begin
          prev  <= cur;
          prevv <= 1'b1;
        end
      end
      pms_pkg::BK_RM_EMIT: begin
        if (load_out) begin
          emit_idx <= emit_idx + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/priority_message_scheduler.sv
// ----------------------------------------------------------------------------
// priority_message_scheduler
// Per-priority message FIFOs with a ready bitmap: post, dispatch, remove.
// ----------------------------------------------------------------------------
//  channel | signals                                  | beat taken when
//  --------+------------------------------------------+---------------------
//  input   | in_valid, in_stall, in_data              | in_valid & !in_stall
//  output  | out_valid, out_stall, out_data           | out_valid & !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
//  A remove walks its priority queue link by link, then sends one beat per
//  freed handle (last low) and a closing beat that carries the removed count.
//  Reset (rst, synchronous) clears the ready bitmap and handshake state;
//  queue pointers and slot memories hold garbage until written.
//  The front keeps taking beats into a two-entry command queue while the
//  back part waits on out_stall; in_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module priority_message_scheduler #(
  parameter int NUM_PRIORITIES = 8,
  parameter int MSG_SLOTS      = 32,
  parameter int MAX_TASKS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pms_pkg::msg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pms_pkg::msg_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data
);

  logic              q_full;
  logic              push;
  logic              pop;
  logic              cmd_valid;
  pms_pkg::pms_cmd_t cmd_wr;
  pms_pkg::pms_cmd_t cmd_rd;

  // classify and hold configuration
  pms_front #(
    .NUM_PRIORITIES(NUM_PRIORITIES),
    .MSG_SLOTS     (MSG_SLOTS),
    .MAX_TASKS     (MAX_TASKS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd_wr),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // decouple front from back
  pms_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cmd_wr),
    .full    (q_full),
    .pop     (pop),
    .rd_valid(cmd_valid),
    .rd_data (cmd_rd)
  );

  // execute commands and drive result beats
  pms_back #(
    .NUM_PRIORITIES(NUM_PRIORITIES),
    .MSG_SLOTS     (MSG_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_in   (cmd_rd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: hw/rtl/pms_checker.sv
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks on the scheduler's result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pms_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input pms_pkg::msg_out_t out_data
);

  `PMS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `PMS_ASSERT_IMP(a_err_single, clk, rst, out_valid && out_data.status != pms_pkg::ST_OK, out_data.last && !out_data.handle_valid)
  `PMS_ASSERT_IMP(a_mid_is_handle, clk, rst, out_valid && !out_data.last, out_data.handle_valid && out_data.removed_count == 6'd0)
  `PMS_ASSERT_IMP(a_count_on_close, clk, rst, out_valid && out_data.removed_count != 6'd0, out_data.last && !out_data.handle_valid)

endmodule

bind priority_message_scheduler pms_checker u_pms_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
